/* rtl/core/pnsuq_pkg.sv */
// Shared types and constants for the per-node sequenced update queue.
`default_nettype none

package pnsuq_pkg;

  localparam int unsigned NODE_W  = 4;   // node_index field width
  localparam int unsigned SEQ_W   = 8;   // sequence numbers wrap at 256
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = 64;  // payload field width on the ports
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNT_OUT_W = 4;

  localparam logic [SEQ_W-1:0] FIRST_SEQ_RESET = 8'd1;
  localparam logic [SEQ_W-1:0] BYTE_MASK       = 8'hFF;

  // register index, taken from paddr[2]
  localparam logic REG_FIRST_SEQ = 1'b0;

  localparam logic [STAT_W-1:0] STATUS_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_CHECK   = 2'd1,
    OP_ACK     = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  // update applied to the working copy of a queue's state
  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_ENQ   = 2'd1,
    UPD_POP   = 2'd2,
    UPD_CLEAR = 2'd3
  } upd_t;

  // what goes into the result register
  typedef enum logic [2:0] {
    RES_NONE    = 3'd0,
    RES_ENQ     = 3'd1,
    RES_FULL    = 3'd2,
    RES_IGNORED = 3'd3,
    RES_REPORT  = 3'd4
  } res_t;

  typedef struct packed {
    logic latch;     // take the input transfer
    logic load;      // load working state from the slot tables
    upd_t upd;
    logic wr_state;  // write working state back to the slot tables
    logic capture;   // load the result register
    res_t res;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic last;      // exactly one entry left
    logic seq_le;    // front sequence <= node sequence
    logic seq_eq;    // front sequence == node sequence
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/pnsuq_ctrl.sv */
// Sequencing state machine for the per-node update queue.
`default_nettype none

module pnsuq_ctrl (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire                logic out_ready,
  input  pnsuq_pkg::sts_t    sts,
  output pnsuq_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_LOAD,
    S_OP,
    S_WAIT,
    S_EXAM
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.latch    = 1'b0;
    cmd.load     = 1'b0;
    cmd.upd      = pnsuq_pkg::UPD_NONE;
    cmd.wr_state = 1'b0;
    cmd.capture  = 1'b0;
    cmd.res      = pnsuq_pkg::RES_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_LOAD;
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_OP;
      end
      S_OP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          unique case (sts.op)
            pnsuq_pkg::OP_ENQUEUE: begin
              cmd.capture = 1'b1;
              if (sts.full) begin
                cmd.res = pnsuq_pkg::RES_FULL;
              end else begin
                cmd.upd      = pnsuq_pkg::UPD_ENQ;
                cmd.wr_state = 1'b1;
                cmd.res      = pnsuq_pkg::RES_ENQ;
              end
            end
            pnsuq_pkg::OP_CHECK: begin
              if (sts.empty) begin
                cmd.capture = 1'b1;
                cmd.res     = pnsuq_pkg::RES_NONE;
              end else begin
                state_nxt = S_WAIT;
              end
            end
            pnsuq_pkg::OP_ACK: begin
              if (sts.empty) begin
                cmd.capture = 1'b1;
                cmd.res     = pnsuq_pkg::RES_IGNORED;
              end else begin
                state_nxt = S_WAIT;
              end
            end
            pnsuq_pkg::OP_CLEAR: begin
              cmd.upd      = pnsuq_pkg::UPD_CLEAR;
              cmd.wr_state = 1'b1;
              cmd.capture  = 1'b1;
              cmd.res      = pnsuq_pkg::RES_NONE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_WAIT: state_nxt = S_EXAM;
      S_EXAM: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (sts.op == pnsuq_pkg::OP_CHECK) begin
            if (sts.seq_le) begin
              cmd.upd = pnsuq_pkg::UPD_POP;
              if (sts.last) begin
                cmd.wr_state = 1'b1;
                cmd.capture  = 1'b1;
                cmd.res      = pnsuq_pkg::RES_NONE;
              end else begin
                state_nxt = S_WAIT;
              end
            end else begin
              cmd.wr_state = 1'b1;
              cmd.capture  = 1'b1;
              cmd.res      = pnsuq_pkg::RES_REPORT;
            end
          end else begin
            cmd.capture = 1'b1;
            if (sts.seq_eq) begin
              cmd.upd      = pnsuq_pkg::UPD_POP;
              cmd.wr_state = 1'b1;
              cmd.res      = pnsuq_pkg::RES_NONE;
            end else begin
              cmd.res = pnsuq_pkg::RES_IGNORED;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = cmd.capture ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pnsuq_dp.sv */
// Datapath: slot tables, entry store, working state and result register.
`default_nettype none

module pnsuq_dp #(
  parameter int unsigned NODE_SLOTS    = 16,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  pnsuq_pkg::cmd_t    cmd,
  output pnsuq_pkg::sts_t    sts,
  input  wire                logic [pnsuq_pkg::SEQ_W-1:0]  first_seq,
  input  wire                logic                         cfg_wr,
  input  wire                logic [1:0]                   in_opcode,
  input  wire                logic [pnsuq_pkg::NODE_W-1:0] in_node_index,
  input  wire                logic [pnsuq_pkg::KIND_W-1:0] in_update_kind,
  input  wire                logic [pnsuq_pkg::DATA_W-1:0] in_payload_bytes,
  input  wire                logic [pnsuq_pkg::LEN_W-1:0]  in_payload_length,
  input  wire                logic [pnsuq_pkg::SEQ_W-1:0]  in_node_sequence,
  output logic [pnsuq_pkg::STAT_W-1:0]    out_status,
  output logic                            out_update_found,
  output logic [pnsuq_pkg::KIND_W-1:0]    out_reported_kind,
  output logic [pnsuq_pkg::SEQ_W-1:0]     out_reported_sequence,
  output logic [pnsuq_pkg::DATA_W-1:0]    out_reported_payload,
  output logic [pnsuq_pkg::CNT_OUT_W-1:0] out_pending_count
);

  localparam int unsigned SLOT_W  = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TOTAL   = NODE_SLOTS * QUEUE_DEPTH;
  localparam int unsigned ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int unsigned PAY_W   = PAYLOAD_BYTES * 8;
  localparam int unsigned SEQ_W   = pnsuq_pkg::SEQ_W;
  localparam int unsigned KIND_W  = pnsuq_pkg::KIND_W;
  localparam int unsigned ENT_W   = KIND_W + SEQ_W + PAY_W;
  localparam int unsigned ST_W    = PTR_W + CNT_W;
  localparam int unsigned NODE_N  = 1 << pnsuq_pkg::NODE_W;

  // node_index modulo NODE_SLOTS, as a constant table
  logic [SLOT_W-1:0] slot_tab [NODE_N];
  for (genvar v = 0; v < NODE_N; v++) begin : g_slot
    assign slot_tab[v] = SLOT_W'(v % NODE_SLOTS);
  end

  // latched item
  pnsuq_pkg::op_t     op_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [KIND_W-1:0]  kind_r;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [SEQ_W-1:0]   nseq_r;

  // working copy of the addressed queue
  logic [PTR_W-1:0]   head_r, head_nxt, head_new, head_inc;
  logic [CNT_W-1:0]   fill_r, fill_nxt, fill_new;
  logic [SEQ_W-1:0]   seq_r, seq_nxt, seq_new;

  // slot tables and entry store
  logic [ST_W-1:0]    st_mem [NODE_SLOTS];
  logic [SEQ_W-1:0]   sq_mem [NODE_SLOTS];
  logic [ENT_W-1:0]   ent_mem [TOTAL];
  logic [ST_W-1:0]    st_rd_r;
  logic [SEQ_W-1:0]   sq_rd_r;
  logic [ENT_W-1:0]   ent_rd_r;
  logic [NODE_SLOTS-1:0] q_vld_r, s_vld_r;

  logic [PTR_W:0]     pos_sum;
  logic [PTR_W-1:0]   enq_pos;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;

  logic [KIND_W-1:0]  ent_kind;
  logic [SEQ_W-1:0]   ent_seq;
  logic [PAY_W-1:0]   ent_pay;

  logic [pnsuq_pkg::STAT_W-1:0] res_status_r, res_status_nxt;
  logic                         res_has_r, res_has_nxt;
  logic [KIND_W-1:0]            res_kind_r, res_kind_nxt;
  logic [SEQ_W-1:0]             res_seq_r, res_seq_nxt;
  logic [PAY_W-1:0]             res_pay_r, res_pay_nxt;
  logic [pnsuq_pkg::CNT_OUT_W-1:0] res_cnt_r;

  assign ent_kind = ent_rd_r[ENT_W-1 -: KIND_W];
  assign ent_seq  = ent_rd_r[PAY_W +: SEQ_W];
  assign ent_pay  = ent_rd_r[PAY_W-1:0];

  // bytes at and past the length are stored as zero
  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      pay_nxt[b*8 +: 8] = (4'(b) < in_payload_length) ? in_payload_bytes[b*8 +: 8] : 8'h00;
    end
  end

  assign head_inc = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign pos_sum  = (PTR_W+1)'(head_r) + (PTR_W+1)'(fill_r);
  assign enq_pos  = (pos_sum >= (PTR_W+1)'(QUEUE_DEPTH)) ?
                    PTR_W'(pos_sum - (PTR_W+1)'(QUEUE_DEPTH)) : PTR_W'(pos_sum);
  assign rd_addr  = ADDR_W'(slot_r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_r);
  assign wr_addr  = ADDR_W'(slot_r) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(enq_pos);

  always_comb begin
    head_new = head_r;
    fill_new = fill_r;
    seq_new  = seq_r;
    case (cmd.upd)
      pnsuq_pkg::UPD_ENQ: begin
        fill_new = fill_r + 1'b1;
        seq_new  = seq_r + 1'b1;
      end
      pnsuq_pkg::UPD_POP: begin
        head_new = head_inc;
        fill_new = fill_r - 1'b1;
      end
      pnsuq_pkg::UPD_CLEAR: begin
        head_new = '0;
        fill_new = '0;
      end
      default: ;
    endcase

    if (cmd.load) begin
      head_nxt = q_vld_r[slot_r] ? st_rd_r[CNT_W +: PTR_W] : '0;
      fill_nxt = q_vld_r[slot_r] ? st_rd_r[CNT_W-1:0] : '0;
      seq_nxt  = s_vld_r[slot_r] ? sq_rd_r : first_seq;
    end else begin
      head_nxt = head_new;
      fill_nxt = fill_new;
      seq_nxt  = seq_new;
    end
  end

  assign sts.op     = op_r;
  assign sts.full   = (fill_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty  = (fill_r == '0);
  assign sts.last   = (fill_r == CNT_W'(1));
  assign sts.seq_le = (ent_seq <= nseq_r);
  assign sts.seq_eq = (ent_seq == nseq_r);

  // valid bits stand in for the reset values of the slot tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= '0;
      s_vld_r <= '0;
    end else if (cfg_wr) begin
      s_vld_r <= '0;
    end else if (cmd.wr_state) begin
      q_vld_r[slot_r] <= 1'b1;
      s_vld_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    st_rd_r  <= st_mem[slot_r];
    sq_rd_r  <= sq_mem[slot_r];
    ent_rd_r <= ent_mem[rd_addr];
    if (cmd.wr_state) begin
      st_mem[slot_r] <= {head_new, fill_new};
      sq_mem[slot_r] <= seq_new;
    end
    if (cmd.upd == pnsuq_pkg::UPD_ENQ) begin
      ent_mem[wr_addr] <= {kind_r, seq_r, pay_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= pnsuq_pkg::op_t'(in_opcode);
      slot_r <= slot_tab[in_node_index];
      kind_r <= in_update_kind;
      pay_r  <= pay_nxt;
      nseq_r <= in_node_sequence;
    end
    head_r <= head_nxt;
    fill_r <= fill_nxt;
    seq_r  <= seq_nxt;
  end

  // result fields, zero unless the result kind sets them
  always_comb begin
    res_status_nxt = pnsuq_pkg::STATUS_DONE;
    res_has_nxt    = 1'b0;
    res_kind_nxt   = '0;
    res_seq_nxt    = '0;
    res_pay_nxt    = '0;
    case (cmd.res)
      pnsuq_pkg::RES_ENQ:     res_seq_nxt    = seq_r;
      pnsuq_pkg::RES_FULL:    res_status_nxt = pnsuq_pkg::STATUS_FULL;
      pnsuq_pkg::RES_IGNORED: res_status_nxt = pnsuq_pkg::STATUS_IGNORED;
      pnsuq_pkg::RES_REPORT: begin
        res_has_nxt  = 1'b1;
        res_kind_nxt = ent_kind;
        res_seq_nxt  = ent_seq & pnsuq_pkg::BYTE_MASK;
        res_pay_nxt  = ent_pay;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_status_r <= res_status_nxt;
      res_has_r    <= res_has_nxt;
      res_kind_r   <= res_kind_nxt;
      res_seq_r    <= res_seq_nxt;
      res_pay_r    <= res_pay_nxt;
      res_cnt_r    <= pnsuq_pkg::CNT_OUT_W'(fill_new);
    end
  end

  assign out_status            = res_status_r;
  assign out_update_found      = res_has_r;
  assign out_reported_kind     = res_kind_r;
  assign out_reported_sequence = res_seq_r;
  assign out_reported_payload  = pnsuq_pkg::DATA_W'(res_pay_r);
  assign out_pending_count     = res_cnt_r;

endmodule

`default_nettype wire

/* rtl/core/per_node_sequenced_update_queue.sv */
// Top level: per-node sequenced update queue with its configuration register.
// Flow: the input transfer is latched, the slot tables are read and loaded into
//   the working state, and dispatch loads the result for enqueue, clear and
//   empty-queue cases; check and ack pass through wait and examine for each front
//   entry, waiting on the registered entry-store read. One item at a time.
// Reset: all queues empty, every sequence counter at first_sequence (1); slot
//   state is tracked by valid bits, so no clearing pass is needed.
`default_nettype none

module per_node_sequenced_update_queue #(
  parameter int unsigned NODE_SLOTS    = 16,
  parameter int unsigned QUEUE_DEPTH   = 8,
  parameter int unsigned PAYLOAD_BYTES = 8
) (
  input  wire  logic        clk,
  input  wire  logic        rst_n,

  // configuration port
  input  wire  logic        psel,
  input  wire  logic        penable,
  input  wire  logic        pwrite,
  input  wire  logic [2:0]  paddr,
  input  wire  logic [31:0] pwdata,
  output logic [31:0]       prdata,
  output logic              pready,

  // input channel
  input  wire  logic        in_valid,
  output logic              in_ready,
  input  wire  logic [1:0]  in_opcode,
  input  wire  logic [3:0]  in_node_index,
  input  wire  logic [1:0]  in_update_kind,
  input  wire  logic [63:0] in_payload_bytes,
  input  wire  logic [3:0]  in_payload_length,
  input  wire  logic [7:0]  in_node_sequence,

  // result channel
  output logic              out_valid,
  input  wire  logic        out_ready,
  output logic [1:0]        out_status,
  output logic              out_update_found,
  output logic [1:0]        out_reported_kind,
  output logic [7:0]        out_reported_sequence,
  output logic [63:0]       out_reported_payload,
  output logic [3:0]        out_pending_count
);

  pnsuq_pkg::cmd_t cmd;
  pnsuq_pkg::sts_t sts;

  logic [pnsuq_pkg::SEQ_W-1:0] first_seq_r;
  logic                        cfg_wr;

  // Register write lands in the access phase; pready is tied high so
  // every access completes without wait states. paddr[2] selects the register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == pnsuq_pkg::REG_FIRST_SEQ);
  assign prdata = (paddr[2] == pnsuq_pkg::REG_FIRST_SEQ) ? {24'd0, first_seq_r} : 32'd0;

  // A write of first_sequence also reloads every node's counter: the
  // datapath drops its sequence valid bits on cfg_wr, so each slot reads
  // the new value until it next enqueues.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_seq_r <= pnsuq_pkg::FIRST_SEQ_RESET;
    end else if (cfg_wr) begin
      first_seq_r <= pwdata[pnsuq_pkg::SEQ_W-1:0];
    end
  end

  // Controller walks each transfer through slot read, dispatch and, for
  // check and ack, the front-entry loop; one item is in flight at a time,
  // while a finished result may still wait in the output register.
  pnsuq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pnsuq_dp #(
    .NODE_SLOTS    (NODE_SLOTS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .first_seq             (first_seq_r),
    .cfg_wr                (cfg_wr),
    .in_opcode             (in_opcode),
    .in_node_index         (in_node_index),
    .in_update_kind        (in_update_kind),
    .in_payload_bytes      (in_payload_bytes),
    .in_payload_length     (in_payload_length),
    .in_node_sequence      (in_node_sequence),
    .out_status            (out_status),
    .out_update_found      (out_update_found),
    .out_reported_kind     (out_reported_kind),
    .out_reported_sequence (out_reported_sequence),
    .out_reported_payload  (out_reported_payload),
    .out_pending_count     (out_pending_count)
  );

endmodule

`default_nettype wire

/* sim/per_node_sequenced_update_queue_tb.sv */
// Self-checking testbench for the per-node sequenced update queue.
module per_node_sequenced_update_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NODE_SLOTS    = 16;
  localparam int unsigned QUEUE_DEPTH   = 8;
  localparam int unsigned PAYLOAD_BYTES = 8;
  // cycles with no transfer on any port before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 4000;

  // one request as presented on the input channel
  typedef struct packed {
    pnsuq_pkg::op_t op;
    logic [3:0]  node;
    logic [1:0]  kind;
    logic [63:0] data;
    logic [3:0]  len;
    logic [7:0]  nseq;
  } update_req_t;

  // one result as seen on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic        update_found;
    logic [1:0]  kind;
    logic [7:0]  seq_num;
    logic [63:0] payload;
    logic [3:0]  pending;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = '0;
  logic [3:0]  in_node_index = '0;
  logic [1:0]  in_update_kind = '0;
  logic [63:0] in_payload_bytes = '0;
  logic [3:0]  in_payload_length = '0;
  logic [7:0]  in_node_sequence = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic        out_update_found;
  logic [1:0]  out_reported_kind;
  logic [7:0]  out_reported_sequence;
  logic [63:0] out_reported_payload;
  logic [3:0]  out_pending_count;

  per_node_sequenced_update_queue #(
    .NODE_SLOTS    (NODE_SLOTS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_opcode             (in_opcode),
    .in_node_index         (in_node_index),
    .in_update_kind        (in_update_kind),
    .in_payload_bytes      (in_payload_bytes),
    .in_payload_length     (in_payload_length),
    .in_node_sequence      (in_node_sequence),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_update_found      (out_update_found),
    .out_reported_kind     (out_reported_kind),
    .out_reported_sequence (out_reported_sequence),
    .out_reported_payload  (out_reported_payload),
    .out_pending_count     (out_pending_count)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Queue model: private copy of every slot's FIFO and sequence counter
  // ---------------------------------------------------------------------
  logic [63:0] q_data  [NODE_SLOTS][QUEUE_DEPTH];
  logic [1:0]  q_kind  [NODE_SLOTS][QUEUE_DEPTH];
  logic [7:0]  q_seq   [NODE_SLOTS][QUEUE_DEPTH];
  logic [3:0]  q_len   [NODE_SLOTS][QUEUE_DEPTH];
  int unsigned q_head  [NODE_SLOTS];
  int unsigned q_fill  [NODE_SLOTS];
  logic [7:0]  seq_counter [NODE_SLOTS];
  logic [7:0]  first_seq_model;

  // results still owed by the block, oldest first
  reply_t reply_fifo [$];
  int     mismatches = 0;

  // sender pacing: burst length left and the largest gap of this phase
  int     burst_left = 0;
  int     gap_max = 0;

  function automatic logic [63:0] keep_bytes(logic [3:0] len);
    if (len >= 4'd8) return '1;
    return (64'd1 << (8 * int'(len))) - 64'd1;
  endfunction

  function automatic void drop_front(int unsigned slot);
    q_head[slot] = (q_head[slot] + 1) % QUEUE_DEPTH;
    q_fill[slot] = q_fill[slot] - 1;
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic reply_t model_queue_op(update_req_t req);
    reply_t      rsp;
    int unsigned slot;
    int unsigned pos;
    logic [3:0]  len;
    rsp  = '0;
    slot = req.node % NODE_SLOTS;
    case (req.op)
      pnsuq_pkg::OP_ENQUEUE: begin
        if (q_fill[slot] >= QUEUE_DEPTH) begin
          rsp.status = pnsuq_pkg::STATUS_FULL;
        end else begin
          pos = (q_head[slot] + q_fill[slot]) % QUEUE_DEPTH;
          // over-long lengths saturate to the payload width
          len = (req.len > 4'(PAYLOAD_BYTES)) ? 4'(PAYLOAD_BYTES) : req.len;
          q_data[slot][pos] = req.data & keep_bytes(len);
          q_kind[slot][pos] = req.kind;
          q_seq[slot][pos]  = seq_counter[slot];
          q_len[slot][pos]  = len;
          rsp.seq_num       = seq_counter[slot];
          seq_counter[slot] = seq_counter[slot] + 8'd1;
          q_fill[slot]      = q_fill[slot] + 1;
        end
      end
      pnsuq_pkg::OP_CHECK: begin
        // stale front entries go first; plain unsigned compare, no wrap care
        while (q_fill[slot] != 0 && q_seq[slot][q_head[slot]] <= req.nseq)
          drop_front(slot);
        if (q_fill[slot] != 0) begin
          pos              = q_head[slot];
          rsp.update_found = 1'b1;
          rsp.kind         = q_kind[slot][pos];
          rsp.seq_num      = q_seq[slot][pos];
          rsp.payload      = q_data[slot][pos] & keep_bytes(q_len[slot][pos]);
        end
      end
      pnsuq_pkg::OP_ACK: begin
        if (q_fill[slot] != 0 && q_seq[slot][q_head[slot]] == req.nseq)
          drop_front(slot);
        else
          rsp.status = pnsuq_pkg::STATUS_IGNORED;
      end
      default: begin
        q_head[slot] = 0;
        q_fill[slot] = 0;
      end
    endcase
    rsp.pending = 4'(q_fill[slot]);
    return rsp;
  endfunction

  task automatic reset_model();
    first_seq_model = pnsuq_pkg::FIRST_SEQ_RESET;
    for (int s = 0; s < NODE_SLOTS; s++) begin
      q_head[s] = 0;
      q_fill[s] = 0;
      seq_counter[s] = pnsuq_pkg::FIRST_SEQ_RESET;
      for (int p = 0; p < QUEUE_DEPTH; p++) begin
        q_data[s][p] = '0;
        q_kind[s][p] = '0;
        q_seq[s][p]  = '0;
        q_len[s][p]  = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------
  function automatic update_req_t make_req(pnsuq_pkg::op_t op, logic [3:0] node,
                                           logic [1:0] kind, logic [63:0] data,
                                           logic [3:0] len, logic [7:0] nseq);
    update_req_t r;
    r.op = op; r.node = node; r.kind = kind;
    r.data = data; r.len = len; r.nseq = nseq;
    return r;
  endfunction

  // Presents one request and holds it until the transfer. Entered and left
  // at a falling edge; valid is only dropped when a gap is due, so back to
  // back items keep it high.
  task automatic send_update(update_req_t req);
    int gap;
    if (burst_left <= 0) begin
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_opcode         = req.op;
    in_node_index     = req.node;
    in_update_kind    = req.kind;
    in_payload_bytes  = req.data;
    in_payload_length = req.len;
    in_node_sequence  = req.nseq;
    in_valid          = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge: update the model now
    reply_fifo.push_back(model_queue_op(req));
    burst_left--;
    @(negedge clk);
  endtask

  // Drops valid, waits for every owed result, then lets the pipeline settle.
  task automatic drain();
    in_valid = 1'b0;
    burst_left = 0;
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Writes first_sequence over the APB-style port and reads it back.
  // Only called when the block is idle.
  task automatic set_first_sequence(logic [7:0] value);
    drain();
    paddr   = {pnsuq_pkg::REG_FIRST_SEQ, 2'b00};
    pwdata  = {24'($urandom_range(0, 24'hFFFFFF)), value}; // upper bits are ignored
    pwrite  = 1'b1;
    psel    = 1'b1;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // counters of every slot reload; queued entries stay as they are
    first_seq_model = value;
    for (int s = 0; s < NODE_SLOTS; s++) seq_counter[s] = value;
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== first_seq_model) begin
      mismatches++;
      $display("%0t ns: first_sequence readback expected %0h got %0h",
               $time, first_seq_model, prdata[7:0]);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Output side: stall pattern and result checker
  // ---------------------------------------------------------------------
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_run_left = 0;

  // Modes: always ready, mostly ready, or long alternating runs of
  // ready and stall.
  always @(negedge clk) begin
    if (rx_mode_left <= 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(16, 256);
    end
    rx_mode_left--;
    case (rx_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run_left <= 0) begin
          out_ready   = !out_ready;
          rx_run_left = $urandom_range(1, 24);
        end
        rx_run_left--;
      end
    endcase
  end

  function automatic void show_mismatch(string field, logic [63:0] want, logic [63:0] got);
    $display("%0t ns: %s expected %0h got %0h", $time, field, want, got);
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && out_valid && out_ready) begin
      got.status       = out_status;
      got.update_found = out_update_found;
      got.kind         = out_reported_kind;
      got.seq_num      = out_reported_sequence;
      got.payload      = out_reported_payload;
      got.pending      = out_pending_count;
      if (reply_fifo.size() == 0) begin
        mismatches++;
        $display("%0t ns: result transfer expected none got status %0h pending %0h",
                 $time, got.status, got.pending);
      end else begin
        want = reply_fifo.pop_front();
        if (got !== want) begin
          mismatches++;
          if (got.status !== want.status)
            show_mismatch("status", 64'(want.status), 64'(got.status));
          if (got.update_found !== want.update_found)
            show_mismatch("update_found", 64'(want.update_found), 64'(got.update_found));
          if (got.kind !== want.kind)
            show_mismatch("reported_kind", 64'(want.kind), 64'(got.kind));
          if (got.seq_num !== want.seq_num)
            show_mismatch("reported_sequence", 64'(want.seq_num), 64'(got.seq_num));
          if (got.payload !== want.payload)
            show_mismatch("reported_payload", want.payload, got.payload);
          if (got.pending !== want.pending)
            show_mismatch("pending_count", 64'(want.pending), 64'(got.pending));
        end
      end
    end
  end

  // Watchdog: any transfer on any port restarts the count.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Fill the top slot with every kind and the length extremes, then overflow.
  task automatic test_enqueue_and_full();
    gap_max = 3;
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd0, '1, 4'd0, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd1, '1, 4'd1, 8'hFF));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd2, '1, 4'd7, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd3, '1, 4'd8, 8'd0));
    // lengths past the payload width saturate
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd3,
                         64'h0123_4567_89AB_CDEF, 4'd9, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd0, '1, 4'd15, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd1, '0, 4'd8, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd2,
                         64'hFEDC_BA98_7654_3210, 4'd4, 8'd0));
    // ninth entry: queue full, rejected
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd15, 2'd3, '1, 4'd8, 8'd0));
  endtask

  // Check, ack match and mismatch, and clear on a non-empty and an empty queue.
  task automatic test_check_ack_clear();
    send_update(make_req(pnsuq_pkg::OP_CHECK, 4'd15, 2'd0, '0, 4'd0, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ACK,   4'd15, 2'd0, '0, 4'd0, 8'd0));  // wrong sequence
    send_update(make_req(pnsuq_pkg::OP_ACK,   4'd15, 2'd0, '0, 4'd0, 8'd1));  // matches front
    send_update(make_req(pnsuq_pkg::OP_CHECK, 4'd15, 2'd0, '0, 4'd0, 8'd3));  // drops two stale
    send_update(make_req(pnsuq_pkg::OP_CLEAR, 4'd15, 2'd0, '0, 4'd0, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_CLEAR, 4'd15, 2'd0, '0, 4'd0, 8'd0));  // already empty
    send_update(make_req(pnsuq_pkg::OP_ACK,   4'd15, 2'd0, '0, 4'd0, 8'd0));  // empty queue
    send_update(make_req(pnsuq_pkg::OP_CHECK, 4'd0,  2'd0, '0, 4'd0, 8'hFF)); // nothing queued
  endtask

  // Counter wraps past 255; a check with 255 then drops all three entries, the wrapped one too.
  task automatic test_sequence_wrap();
    set_first_sequence(8'd254);
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd0, 2'd1,
                         64'hA5A5_5A5A_0F0F_F0F0, 4'd8, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd0, 2'd2,
                         64'h1122_3344_5566_7788, 4'd3, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_ENQUEUE, 4'd0, 2'd3,
                         64'h8877_6655_4433_2211, 4'd5, 8'd0));
    send_update(make_req(pnsuq_pkg::OP_CHECK,   4'd0, 2'd0, '0, 4'd0, 8'hFF));
    send_update(make_req(pnsuq_pkg::OP_ACK,     4'd0, 2'd0, '0, 4'd0, 8'd0));
  endtask

  // Mostly well-formed traffic on a few busy slots, with noise on the rest.
  task automatic test_random_traffic(int n_items, logic [7:0] start_seq, int gap_limit);
    update_req_t req;
    int          pick;
    int unsigned slot;
    logic [7:0]  front;
    set_first_sequence(start_seq);
    gap_max = gap_limit;
    for (int i = 0; i < n_items; i++) begin
      req.node = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 2))
                                             : 4'($urandom_range(0, 15));
      slot     = req.node % NODE_SLOTS;
      pick     = $urandom_range(0, 99);
      req.op   = (pick < 40) ? pnsuq_pkg::OP_ENQUEUE :
                 (pick < 65) ? pnsuq_pkg::OP_CHECK :
                 (pick < 93) ? pnsuq_pkg::OP_ACK : pnsuq_pkg::OP_CLEAR;
      req.kind = 2'($urandom_range(0, 3));
      pick     = $urandom_range(0, 19);
      req.data = (pick == 0) ? '0 : (pick < 3) ? '1 : {$urandom, $urandom};
      req.len  = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 8))
                                             : 4'($urandom_range(9, 15));
      // aim the node sequence at the queue front most of the time
      front = (q_fill[slot] != 0) ? q_seq[slot][q_head[slot]] : seq_counter[slot];
      if ($urandom_range(0, 9) < 7) begin
        if (req.op == pnsuq_pkg::OP_CHECK)
          req.nseq = front + 8'($urandom_range(0, 5)) - 8'd1;
        else
          req.nseq = front;
      end else begin
        req.nseq = 8'($urandom_range(0, 255));
      end
      send_update(req);
    end
  endtask

  initial begin
    reset_model();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_enqueue_and_full();
    test_check_ack_clear();
    test_sequence_wrap();

    // several register settings, extremes included; idling varies by phase
    test_random_traffic(400, pnsuq_pkg::FIRST_SEQ_RESET, 0);
    test_random_traffic(400, 8'd0, 6);
    test_random_traffic(400, 8'hFF, 20);
    test_random_traffic(400, 8'd250, 4);
    test_random_traffic(400, 8'($urandom_range(0, 255)), 10);

    drain();
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/pnsuq_pkg.sv
rtl/core/pnsuq_ctrl.sv
rtl/core/pnsuq_dp.sv
rtl/core/per_node_sequenced_update_queue.sv
sim/per_node_sequenced_update_queue_tb.sv
